[src/dema_pkg.sv]
package dema_pkg;

    // Frame geometry and number formats
    localparam int BAND_COUNT    = 8;
    localparam int LEVEL_W       = 16;
    localparam int FRACTION_BITS = 16;
    localparam int AVG_W         = LEVEL_W + FRACTION_BITS;
    localparam int GAIN_W        = 16;
    localparam int CFG_IDX_W     = 3;

    // Band positions used by the classifier
    localparam int BAND_ZERO  = 0;
    localparam int BAND_ONE   = 1;
    localparam int BAND_TWO   = 2;
    localparam int BAND_THREE = 3;
    localparam int BAND_FOUR  = 4;
    localparam int BAND_SIX   = 6;
    localparam int BAND_SEVEN = 7;

    // Register reset values
    localparam logic [GAIN_W-1:0] SLOW_GAIN_RST   = 16'd655;
    localparam logic [GAIN_W-1:0] FAST_GAIN_RST   = 16'd13107;
    localparam logic [LEVEL_W-1:0] RATE_MARGIN_RST = 16'd40;
    localparam logic [LEVEL_W-1:0] RATE_LIMIT_RST  = 16'd200;
    localparam logic [LEVEL_W-1:0] HIGH_MARGIN_RST = 16'd15;
    localparam logic [LEVEL_W-1:0] MID_MARGIN_RST  = 16'd20;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SLOW_GAIN   = 3'd0,
        CFG_FAST_GAIN   = 3'd1,
        CFG_RATE_MARGIN = 3'd2,
        CFG_RATE_LIMIT  = 3'd3,
        CFG_HIGH_MARGIN = 3'd4,
        CFG_MID_MARGIN  = 3'd5
    } t_cfg_idx;

    // Hive condition codes
    typedef enum logic [2:0] {
        COND_NORMAL      = 3'd0,
        COND_STRESS      = 3'd1,
        COND_QUEENLESS   = 3'd2,
        COND_QUEEN_SOUND = 3'd3,
        COND_ROBBING     = 3'd4
    } t_cond;

    typedef logic [AVG_W-1:0] t_avg;

    // Integer level to fixed point
    function automatic t_avg to_fixed(input logic [LEVEL_W-1:0] level);
        return {level, {FRACTION_BITS{1'b0}}};
    endfunction

    // Fast average above slow average plus an integer margin
    function automatic logic rose(input t_avg fast, input t_avg slow,
                                  input logic [LEVEL_W-1:0] margin);
        logic [AVG_W:0] bound;
        bound = {1'b0, slow} + {1'b0, to_fixed(margin)};
        return {1'b0, fast} > bound;
    endfunction

endpackage

[src/dema_lane.sv]
module dema_lane (
    input  logic                          i_clk,
    input  logic                          i_load,
    input  logic                          i_update,
    input  logic [dema_pkg::LEVEL_W-1:0]  i_level,
    input  logic [dema_pkg::GAIN_W-1:0]   i_gain,
    output logic [dema_pkg::AVG_W-1:0]    o_average
);
    import dema_pkg::*;

    localparam int DIFF_W = AVG_W + 1;
    localparam int PROD_W = DIFF_W + GAIN_W + 1;
    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< (GAIN_W - 1);

    t_avg                      r_avg;
    t_avg                      n_avg;
    t_avg                      sample;
    logic signed [DIFF_W-1:0]  diff;
    logic signed [PROD_W-1:0]  prod;
    logic signed [PROD_W-1:0]  step;

    // old + round((sample - old) * gain / 2^16), identical to the weighted blend
    always_comb begin
        sample = to_fixed(i_level);
        diff   = $signed({1'b0, sample}) - $signed({1'b0, r_avg});
        prod   = PROD_W'(diff) * $signed({1'b0, i_gain});
        step   = (prod + ROUND_HALF) >>> GAIN_W;
        n_avg  = r_avg + step[AVG_W-1:0];
    end

    // Average register: loaded by the first frame, blended afterwards
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_avg <= sample;
        end else if (i_update) begin
            r_avg <= n_avg;
        end
    end

    assign o_average = r_avg;

endmodule

[src/dual_ema_band_anomaly_classifier.sv]
// Two register stages: the averages are registered when a frame is accepted,
// and the classification of those averages is held in the result register.
// One frame per cycle unless the result channel stalls; each average is one
// multiply-add lane and the classifier compares the registered averages.
// Reset (synchronous, active low) restores the register defaults, empties the
// pipeline and clears the primed flag; the first frame then loads the averages.
module dual_ema_band_anomaly_classifier (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // frame channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [dema_pkg::LEVEL_W-1:0]         i_band_zero,
    input  logic [dema_pkg::LEVEL_W-1:0]         i_band_one,
    input  logic [dema_pkg::LEVEL_W-1:0]         i_band_two,
    input  logic [dema_pkg::LEVEL_W-1:0]         i_band_three,
    input  logic [dema_pkg::LEVEL_W-1:0]         i_band_four,
    input  logic [dema_pkg::LEVEL_W-1:0]         i_band_five,
    input  logic [dema_pkg::LEVEL_W-1:0]         i_band_six,
    input  logic [dema_pkg::LEVEL_W-1:0]         i_band_seven,
    input  logic [dema_pkg::LEVEL_W-1:0]         i_crossing_rate,
    input  logic                                 i_motion_seen,
    // result channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [2:0]                           o_hive_condition,
    // configuration channel
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [dema_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [dema_pkg::LEVEL_W-1:0]         i_cfg_data
);
    import dema_pkg::*;

    // Configuration registers
    logic [GAIN_W-1:0]  r_slow_gain;
    logic [GAIN_W-1:0]  r_fast_gain;
    logic [LEVEL_W-1:0] r_rate_margin;
    logic [LEVEL_W-1:0] r_rate_limit;
    logic [LEVEL_W-1:0] r_high_margin;
    logic [LEVEL_W-1:0] r_mid_margin;

    // Control
    logic  r_primed;
    logic  r_s1_valid;
    logic  r_s1_first;
    logic  r_s1_motion;
    logic  r_out_valid;
    t_cond r_out_cond;
    t_cond n_out_cond;

    logic  in_take;
    logic  s1_move;
    logic  load;
    logic  update;

    logic [LEVEL_W-1:0] level [BAND_COUNT];
    t_avg slow_band [BAND_COUNT];
    t_avg fast_band [BAND_COUNT];
    t_avg slow_rate;
    t_avg fast_rate;

    assign o_cfg_ready = 1'b1;

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slow_gain   <= SLOW_GAIN_RST;
            r_fast_gain   <= FAST_GAIN_RST;
            r_rate_margin <= RATE_MARGIN_RST;
            r_rate_limit  <= RATE_LIMIT_RST;
            r_high_margin <= HIGH_MARGIN_RST;
            r_mid_margin  <= MID_MARGIN_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SLOW_GAIN:   r_slow_gain   <= i_cfg_data;
                CFG_FAST_GAIN:   r_fast_gain   <= i_cfg_data;
                CFG_RATE_MARGIN: r_rate_margin <= i_cfg_data;
                CFG_RATE_LIMIT:  r_rate_limit  <= i_cfg_data;
                CFG_HIGH_MARGIN: r_high_margin <= i_cfg_data;
                CFG_MID_MARGIN:  r_mid_margin  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Handshake: stage one moves on when the result register is free or drained
    assign s1_move    = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_s1_valid || s1_move;
    assign in_take    = i_in_valid && o_in_ready;
    assign load       = in_take && !r_primed;
    assign update     = in_take && r_primed;

    assign level[0] = i_band_zero;
    assign level[1] = i_band_one;
    assign level[2] = i_band_two;
    assign level[3] = i_band_three;
    assign level[4] = i_band_four;
    assign level[5] = i_band_five;
    assign level[6] = i_band_six;
    assign level[7] = i_band_seven;

    // Averaging lanes, one per band and speed
    for (genvar b = 0; b < BAND_COUNT; b++) begin : g_band
        dema_lane u_slow (
            .i_clk     (i_clk),
            .i_load    (load),
            .i_update  (update),
            .i_level   (level[b]),
            .i_gain    (r_slow_gain),
            .o_average (slow_band[b])
        );
        dema_lane u_fast (
            .i_clk     (i_clk),
            .i_load    (load),
            .i_update  (update),
            .i_level   (level[b]),
            .i_gain    (r_fast_gain),
            .o_average (fast_band[b])
        );
    end

    dema_lane u_slow_rate (
        .i_clk     (i_clk),
        .i_load    (load),
        .i_update  (update),
        .i_level   (i_crossing_rate),
        .i_gain    (r_slow_gain),
        .o_average (slow_rate)
    );

    dema_lane u_fast_rate (
        .i_clk     (i_clk),
        .i_load    (load),
        .i_update  (update),
        .i_level   (i_crossing_rate),
        .i_gain    (r_fast_gain),
        .o_average (fast_rate)
    );

    // Stage one control and primed flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primed   <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_primed <= 1'b1;
            end
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_first  <= !r_primed;
            r_s1_motion <= i_motion_seen;
        end
    end

    // Priority classification on the freshly updated averages
    always_comb begin
        if (r_s1_first) begin
            n_out_cond = COND_NORMAL;
        end else if (r_s1_motion) begin
            n_out_cond = COND_STRESS;
        end else if (rose(fast_rate, slow_rate, r_rate_margin) ||
                     fast_rate > to_fixed(r_rate_limit)) begin
            n_out_cond = COND_ROBBING;
        end else if (rose(fast_band[BAND_SIX], slow_band[BAND_SIX], r_high_margin) ||
                     rose(fast_band[BAND_SEVEN], slow_band[BAND_SEVEN], r_high_margin)) begin
            n_out_cond = COND_STRESS;
        end else if (rose(fast_band[BAND_THREE], slow_band[BAND_THREE], r_mid_margin) ||
                     rose(fast_band[BAND_FOUR], slow_band[BAND_FOUR], r_mid_margin)) begin
            n_out_cond = COND_QUEEN_SOUND;
        end else if (slow_band[BAND_TWO] > slow_band[BAND_ZERO] &&
                     slow_band[BAND_THREE] > slow_band[BAND_ONE]) begin
            n_out_cond = COND_QUEENLESS;
        end else begin
            n_out_cond = COND_NORMAL;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move && r_s1_valid) begin
            r_out_cond <= n_out_cond;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_hive_condition = r_out_cond;

endmodule
